FILE: rtl/core/world_to_screen_projector_macros.svh
// Assertion macros used by the checker of the projector.
`ifndef WORLD_TO_SCREEN_PROJECTOR_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTOR_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define WSP_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define WSP_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/wsp_pkg.sv
`default_nettype none
package wsp_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int ACC_W     = WORD_W + 3;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int NDC_W     = FRAC_BITS + 3;
  localparam int DIM_W     = 14;
  localparam int SCL_W     = NDC_W + DIM_W + 1;

  // State memory: two sets of 64 words
  localparam int IDX_W     = 6;
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int CAM_BASE  = 32;
  localparam int NUM_WORDS = 35;

  localparam logic SET_LIVE   = 1'b0;
  localparam logic SET_RENDER = 1'b1;

  // Request codes
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_COMMIT  = 2'd1;
  localparam logic [1:0] REQ_PROJ_LV = 2'd2;
  localparam logic [1:0] REQ_PROJ_RD = 2'd3;

  // Status codes
  localparam logic [2:0] ST_VISIBLE  = 3'd0;
  localparam logic [2:0] ST_NO_CAM   = 3'd1;
  localparam logic [2:0] ST_BEHIND   = 3'd2;
  localparam logic [2:0] ST_W_ZERO   = 3'd3;
  localparam logic [2:0] ST_OUT_BND  = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd1920;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd1080;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [IDX_W-1:0]         word_index;
    logic signed [WORD_W-1:0] word_value;
    logic signed [WORD_W-1:0] point_x;
    logic signed [WORD_W-1:0] point_y;
    logic signed [WORD_W-1:0] point_z;
    logic                     tight_limit;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] screen_x;
    logic signed [WORD_W-1:0] screen_y;
    logic [2:0]               status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_COPY, S_CWAIT, S_CAM, S_VIEW, S_VWAIT, S_PROJ, S_PWAIT,
    S_DSTART, S_DRUN, S_SCALE, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    TAG_NONE, TAG_CAM, TAG_VIEW, TAG_PROJ, TAG_COPY
  } tag_t;

  // Saturate an accumulator to a word
  function automatic logic signed [WORD_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > $signed(ACC_W'({1'b0, {(WORD_W-1){1'b1}}}))) begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v < -$signed(ACC_W'({1'b1, {(WORD_W-1){1'b0}}}))) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Saturate a scaled screen value to a word
  function automatic logic signed [WORD_W-1:0] sat_scl(input logic signed [SCL_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > $signed(SCL_W'({1'b0, {(WORD_W-1){1'b1}}}))) begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v < -$signed(SCL_W'({1'b1, {(WORD_W-1){1'b0}}}))) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Magnitude of a signed word
  function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] v);
    return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/wsp_div.sv
`default_nettype none
// Restoring divider: quo = floor(num * 2^F / den), one bit a cycle.
// The caller guarantees num <= 1.5 den, so the quotient fits F+1 bits.
module wsp_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [wsp_pkg::WORD_W-1:0]         num,
  input  logic [wsp_pkg::WORD_W-1:0]         den,
  output logic                               busy,
  output logic [wsp_pkg::QUO_W-1:0]          quo
);
  import wsp_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [WORD_W:0]      rem;
  logic [WORD_W-1:0]    dreg;
  logic [QUO_W-1:0]     bits;
  logic [CNT_W-1:0]     cnt;
  logic [WORD_W:0]      trial;

  assign trial = {rem[WORD_W-1:0], bits[QUO_W-1]};
  assign busy  = (cnt != '0);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(QUO_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {2'b00, num[WORD_W-1:1]};
      bits <= {num[0], {(QUO_W-1){1'b0}}};
      dreg <= den;
      quo  <= '0;
    end else if (busy) begin
      bits <= {bits[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, dreg}) begin
        rem <= trial - {1'b0, dreg};
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/world_to_screen_projector.sv
// Load: the next word is taken in the following cycle.
// Commit: one word copied a cycle through the state memory.
// Project: 3 camera reads, 32 multiply-accumulates on one shared multiplier, the pipeline drains,
// then 17 divider steps and scaling (visible points only), then output.
// A finished result waits in the output register while the next word is taken.
// Synchronous reset: control cleared, state memory reads as zero, sizes 1920 x 1080.
`default_nettype none
module world_to_screen_projector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wsp_pkg::in_word_t                   in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wsp_pkg::out_word_t                  out_word,
  input  logic                                cfg_we,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsp_pkg::DIM_W-1:0]           cfg_data
);
  import wsp_pkg::*;

  localparam logic signed [WORD_W-1:0] ONE_W = WORD_W'(1) <<< FRAC_BITS;
  localparam logic signed [NDC_W-1:0]  ONE_N = NDC_W'(1) <<< FRAC_BITS;

  state_t state, state_next;
  logic [IDX_W-1:0] cnt;

  // configuration
  logic [DIM_W-1:0] scr_w, scr_h;

  // captured request
  logic                     set_sel;
  logic                     tight;
  logic signed [WORD_W-1:0] pt [4];
  logic                     cam_nz;

  // results of the two matrix passes
  logic signed [WORD_W-1:0] tv [4];
  logic signed [WORD_W-1:0] pv [4];

  // memory and its ports
  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic              valid [MEM_DEPTH];
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  tag_t              rd_tag;
  logic [WORD_W-1:0] mem_q;
  logic              vld_q;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;

  // MAC pipeline
  tag_t                     s1_tag, s2_tag;
  logic [IDX_W-1:0]         s1_idx;
  logic [3:0]               s2_idx;
  logic [2*WORD_W-1:0]      prod;
  logic                     s2_neg;
  logic signed [ACC_W-1:0]  acc;

  // decision and scaling
  logic [2:0]               status, status_c;
  logic                     div_start, busy_x, busy_y;
  logic [QUO_W-1:0]         quo_x, quo_y;
  logic signed [SCL_W-1:0]  sx_prod, sy_prod;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= WIDTH_RST;
      scr_h <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  scr_w <= cfg_data;
        CFG_HEIGHT: scr_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (in_word.req_type)
            REQ_LOAD:   state_next = S_IDLE;
            REQ_COMMIT: state_next = S_COPY;
            default:    state_next = S_CAM;
          endcase
        end
      end
      S_COPY:   if (cnt == IDX_W'(NUM_WORDS - 1)) state_next = S_CWAIT;
      S_CWAIT:  state_next = S_IDLE;
      S_CAM:    if (cnt == IDX_W'(2)) state_next = S_VIEW;
      S_VIEW:   if (cnt == IDX_W'(15)) state_next = S_VWAIT;
      S_VWAIT:  state_next = S_PROJ;
      S_PROJ:   if (cnt == IDX_W'(15)) state_next = S_PWAIT;
      S_PWAIT:  if (cnt == IDX_W'(1)) state_next = S_DSTART;
      S_DSTART: state_next = (status_c == ST_VISIBLE) ? S_DRUN : S_FIN;
      S_DRUN:   if (!busy_x && !busy_y) state_next = S_SCALE;
      S_SCALE:  state_next = S_FIN;
      S_FIN:    if (!out_valid || !out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
    end
  end

  // FSM outputs: read port, stall, divider start
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    rd_tag    = TAG_NONE;
    in_stall  = (state != S_IDLE);
    div_start = 1'b0;
    case (state)
      S_COPY: begin
        rd_en   = 1'b1;
        rd_addr = {SET_LIVE, cnt};
        rd_tag  = TAG_COPY;
      end
      S_CAM: begin
        rd_en   = 1'b1;
        rd_addr = {set_sel, IDX_W'(CAM_BASE) + cnt};
        rd_tag  = TAG_CAM;
      end
      S_VIEW: begin
        rd_en   = 1'b1;
        rd_addr = {set_sel, 2'b00, cnt[1:0], cnt[3:2]};
        rd_tag  = TAG_VIEW;
      end
      S_PROJ: begin
        rd_en   = 1'b1;
        rd_addr = {set_sel, 2'b01, cnt[1:0], cnt[3:2]};
        rd_tag  = TAG_PROJ;
      end
      S_DSTART: div_start = (status_c == ST_VISIBLE);
      default: ;
    endcase
  end

  // write port: loads from the input, or the copy sweep
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (in_acc && in_word.req_type == REQ_LOAD &&
        in_word.word_index < IDX_W'(NUM_WORDS)) begin
      we    = 1'b1;
      waddr = {SET_LIVE, in_word.word_index};
      wdata = in_word.word_value;
    end else if (s1_tag == TAG_COPY) begin
      we    = 1'b1;
      waddr = {SET_RENDER, s1_idx};
      wdata = vld_q ? mem_q : '0;
    end
  end

  // state memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  // entry valid bits; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MEM_DEPTH; k++) valid[k] <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      if (we) valid[waddr] <= 1'b1;
      if (rd_en) vld_q <= valid[rd_addr];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_sel <= (in_word.req_type == REQ_PROJ_RD) ? SET_RENDER : SET_LIVE;
      tight   <= in_word.tight_limit;
      pt[0]   <= in_word.point_x;
      pt[1]   <= in_word.point_y;
      pt[2]   <= in_word.point_z;
      pt[3]   <= ONE_W;
    end
  end

  // pipeline tags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= TAG_NONE;
      s2_tag <= TAG_NONE;
    end else begin
      s1_tag <= rd_tag;
      s2_tag <= (s1_tag == TAG_VIEW || s1_tag == TAG_PROJ) ? s1_tag : TAG_NONE;
    end
  end

  // stage 1: magnitude product
  logic [WORD_W-1:0]        rd_val;
  logic signed [WORD_W-1:0] opnd;
  assign rd_val = vld_q ? mem_q : '0;
  assign opnd   = (s1_tag == TAG_PROJ) ? tv[s1_idx[1:0]] : pt[s1_idx[1:0]];

  always_ff @(posedge clk) begin
    s1_idx <= cnt;
    s2_idx <= s1_idx[3:0];
    prod   <= mag(opnd) * mag(rd_val);
    s2_neg <= opnd[WORD_W-1] ^ rd_val[WORD_W-1];
  end

  // camera set test
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cam_nz <= 1'b0;
    end else if (s1_tag == TAG_CAM && rd_val != '0) begin
      cam_nz <= 1'b1;
    end
  end

  // stage 2: truncate, saturate, accumulate
  logic [2*WORD_W-FRAC_BITS-1:0] shp;
  logic [WORD_W-1:0]             lim, mq;
  logic signed [ACC_W-1:0]       qm, acc_n;
  assign shp   = prod[2*WORD_W-1:FRAC_BITS];
  assign lim   = s2_neg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
  assign mq    = (shp > (2*WORD_W-FRAC_BITS)'(lim)) ? lim : shp[WORD_W-1:0];
  assign qm    = s2_neg ? -ACC_W'(mq) : ACC_W'(mq);
  assign acc_n = ((s2_idx[1:0] == 2'd0) ? '0 : acc) + qm;

  always_ff @(posedge clk) begin
    if (s2_tag == TAG_VIEW || s2_tag == TAG_PROJ) begin
      acc <= acc_n;
      if (s2_idx[1:0] == 2'd3) begin
        if (s2_tag == TAG_VIEW) tv[s2_idx[3:2]] <= sat_acc(acc_n);
        else                    pv[s2_idx[3:2]] <= sat_acc(acc_n);
      end
    end
  end

  // status decision with exact bound test
  logic [WORD_W-1:0] ax, ay, aw;
  logic              oob_x, oob_y;
  assign ax = mag(pv[0]);
  assign ay = mag(pv[1]);
  assign aw = mag(pv[3]);
  assign oob_x = tight ? (ax > aw)
                       : ({ax, 1'b0} > ({1'b0, aw, 1'b0} + {2'b00, aw}));
  assign oob_y = tight ? (ay > aw)
                       : ({ay, 1'b0} > ({1'b0, aw, 1'b0} + {2'b00, aw}));

  always_comb begin
    if (!cam_nz)                 status_c = ST_NO_CAM;
    else if (!tv[2][WORD_W-1])   status_c = ST_BEHIND;
    else if (pv[3] == '0)        status_c = ST_W_ZERO;
    else if (oob_x || oob_y)     status_c = ST_OUT_BND;
    else                         status_c = ST_VISIBLE;
  end

  always_ff @(posedge clk) begin
    if (state == S_DSTART) status <= status_c;
  end

  // x and y divided in parallel
  wsp_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ax),
    .den   (aw),
    .busy  (busy_x),
    .quo   (quo_x)
  );

  wsp_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ay),
    .den   (aw),
    .busy  (busy_y),
    .quo   (quo_y)
  );

  // scale to pixels
  logic signed [NDC_W-1:0] nx, ny, ux, uy;
  assign nx = (pv[0][WORD_W-1] ^ pv[3][WORD_W-1]) ? -NDC_W'(quo_x) : NDC_W'(quo_x);
  assign ny = (pv[1][WORD_W-1] ^ pv[3][WORD_W-1]) ? -NDC_W'(quo_y) : NDC_W'(quo_y);
  assign ux = ONE_N + nx;
  assign uy = ONE_N - ny;

  always_ff @(posedge clk) begin
    if (state == S_SCALE) begin
      sx_prod <= SCL_W'(ux) * SCL_W'($signed({1'b0, scr_w}));
      sy_prod <= SCL_W'(uy) * SCL_W'($signed({1'b0, scr_h}));
    end
  end

  // halve toward zero and saturate
  logic signed [SCL_W-1:0] hx, hy;
  assign hx = (sx_prod + $signed(SCL_W'(sx_prod[SCL_W-1]))) >>> 1;
  assign hy = (sy_prod + $signed(SCL_W'(sy_prod[SCL_W-1]))) >>> 1;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || !out_stall)) begin
      out_word.status   <= status;
      out_word.screen_x <= (status == ST_VISIBLE) ? sat_scl(hx) : '0;
      out_word.screen_y <= (status == ST_VISIBLE) ? sat_scl(hy) : '0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/wsp_checker.sv
`default_nettype none
`include "world_to_screen_projector_macros.svh"
// Port-level checks on the projector.
module wsp_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  wsp_pkg::in_word_t                   in_word,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  wsp_pkg::out_word_t                  out_word
);
  import wsp_pkg::*;

  logic acc_in;
  assign acc_in = in_valid && !in_stall;

  `WSP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word), "stalled result word changed")
  `WSP_ASSERT_IMP(a_hidden_zero, clk, rst, out_valid && out_word.status != ST_VISIBLE, out_word.screen_x == '0 && out_word.screen_y == '0, "hidden point has nonzero coordinates")
  `WSP_ASSERT_NXT(a_load_quick, clk, rst, acc_in && in_word.req_type == REQ_LOAD, !in_stall, "load did not finish in one cycle")
  `WSP_ASSERT_NXT(a_commit_busy, clk, rst, acc_in && in_word.req_type == REQ_COMMIT, in_stall, "commit sweep not started")
  `WSP_ASSERT_NXT(a_reset_idle, clk, 1'b0, rst, !out_valid && !in_stall, "not idle after reset")

endmodule

bind world_to_screen_projector wsp_checker u_wsp_checker (.*);
`default_nettype wire
